/* design/nalpp_pkg.sv */
// ----------------------------------------------------------------------------
// nalpp_pkg: shared types and constants of the NAL packet prioritizer
// Class and bin codes, header field masks, fixed-point widths and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package nalpp_pkg;

  // Default GOP length and job queue depth
  localparam int GopFramesDefault  = 16;
  localparam int QueueDepthDefault = 4;

  // Q.16 fixed point
  localparam int OneQ16 = 65536;
  localparam int TgW    = 17;   // holds 1.0 in Q.16
  localparam int WeightW = 10;
  localparam int TermW  = 26;   // 10-bit weight times 1.0
  localparam int ScoreW = 28;   // sum of four terms
  localparam int WholeW = 12;
  localparam int HalvW  = 5;
  localparam logic [HalvW-1:0] MaxHalvings = HalvW'(16);

  // Bin thresholds, strictly greater than
  localparam logic [ScoreW-1:0] ThrHigh    = ScoreW'(1002 * OneQ16);
  localparam logic [ScoreW-1:0] ThrMedHigh = ScoreW'(700 * OneQ16);
  localparam logic [ScoreW-1:0] ThrMedLow  = ScoreW'(200 * OneQ16);

  // NAL header fields
  localparam logic [7:0] HdrTypeMask   = 8'h1F;
  localparam logic [7:0] HdrRefIdcMask = 8'h60;
  localparam logic [7:0] StartCodeOne  = 8'h01;
  localparam logic [4:0] NalTypeUnspec = 5'd0;
  localparam logic [4:0] NalTypeSlice  = 5'd1;
  localparam logic [4:0] NalTypeIdr    = 5'd5;

  // Configuration register indexes
  localparam int CfgIndexW = 8;
  localparam logic [CfgIndexW-1:0] CfgWeightFrameType = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgWeightHeader    = CfgIndexW'(1);
  localparam logic [CfgIndexW-1:0] CfgWeightSlice     = CfgIndexW'(2);
  localparam logic [CfgIndexW-1:0] CfgWeightGop       = CfgIndexW'(3);

  typedef enum logic [2:0] {
    CLS_UNSPEC = 3'd0,
    CLS_IDR    = 3'd1,
    CLS_P      = 3'd2,
    CLS_B      = 3'd3,
    CLS_OTHER  = 3'd4
  } slice_class_e;

  typedef enum logic [1:0] {
    FRAME_IDR = 2'd0,
    FRAME_P   = 2'd1,
    FRAME_B   = 2'd2
  } frame_class_e;

  typedef enum logic [1:0] {
    PS_ZERO = 2'd0,
    PS_HALF = 2'd1,
    PS_ONE  = 2'd2
  } ps_sel_e;

  typedef enum logic [1:0] {
    PRIO_LOW      = 2'd0,
    PRIO_MED_LOW  = 2'd1,
    PRIO_MED_HIGH = 2'd2,
    PRIO_HIGH     = 2'd3
  } prio_e;

  typedef struct packed {
    logic [WeightW-1:0] frame_type;
    logic [WeightW-1:0] header;
    logic [WeightW-1:0] slice;
    logic [WeightW-1:0] gop;
  } weights_t;

  // Result beat as driven to the output register
  typedef struct packed {
    logic [WholeW-1:0] score_whole;
    slice_class_e      slice_class;
    prio_e             priority_res;
  } result_t;

endpackage

`default_nettype wire

/* design/nalpp_scanner.sv */
// ----------------------------------------------------------------------------
// nalpp_scanner: start code scanner
// Shifts packet bytes through a five-byte window and classifies the last
// NAL header of each packet; pushes one class per packet into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nalpp_scanner (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     byte_valid_i,
  output      logic                     byte_ready_o,
  input  wire logic [7:0]               byte_data_i,
  input  wire logic                     byte_last_i,
  input  wire logic                     queue_full_i,
  output      logic                     push_o,
  output      nalpp_pkg::slice_class_e  push_class_o
);

  logic [7:0]              win_q [4];
  logic [7:0]              win_d [4];
  logic [2:0]              seen_q, seen_d;
  logic [2:0]              skip_q, skip_d;
  nalpp_pkg::slice_class_e found_q, found_d;
  nalpp_pkg::slice_class_e hit_class;
  logic [7:0]              hdr;
  logic                    match;
  logic                    seen_full;
  logic                    accept;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign seen_full    = (seen_q == 3'd4);

  assign match = (win_q[0] == 8'h00) && (win_q[1] == 8'h00) &&
                 ((win_q[2] == nalpp_pkg::StartCodeOne) ||
                  ((win_q[2] == 8'h00) && (win_q[3] == nalpp_pkg::StartCodeOne)));
  assign hdr = (win_q[2] == nalpp_pkg::StartCodeOne) ? win_q[3] : byte_data_i;

  always_comb begin
    unique case (hdr[4:0] & nalpp_pkg::HdrTypeMask[4:0])
      nalpp_pkg::NalTypeUnspec: hit_class = nalpp_pkg::CLS_UNSPEC;
      nalpp_pkg::NalTypeIdr:    hit_class = nalpp_pkg::CLS_IDR;
      nalpp_pkg::NalTypeSlice: begin
        hit_class = ((hdr & nalpp_pkg::HdrRefIdcMask) == 8'h00) ?
                    nalpp_pkg::CLS_B : nalpp_pkg::CLS_P;
      end
      default:                  hit_class = nalpp_pkg::CLS_OTHER;
    endcase
  end

  always_comb begin
    win_d   = win_q;
    seen_d  = seen_q;
    skip_d  = skip_q;
    found_d = found_q;
    push_o  = 1'b0;
    if (accept) begin
      // test the window only once four bytes sit behind the current one
      if (seen_full) begin
        if (skip_q != 3'd0) begin
          skip_d = skip_q - 3'd1;
        end else if (match) begin
          found_d = hit_class;
          skip_d  = 3'd4;
        end
      end
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = win_q[3];
      win_d[3] = byte_data_i;
      if (!seen_full) begin
        seen_d = seen_q + 3'd1;
      end
      if (byte_last_i) begin
        push_o = 1'b1;
        for (int i = 0; i < 4; i++) begin
          win_d[i] = 8'h00;
        end
        seen_d  = 3'd0;
        skip_d  = 3'd0;
        found_d = nalpp_pkg::CLS_UNSPEC;
      end
    end
  end

  // class of this packet including the test made on its last byte
  always_comb begin
    push_class_o = found_q;
    if (seen_full && (skip_q == 3'd0) && match) begin
      push_class_o = hit_class;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= 8'h00;
      end
      seen_q  <= 3'd0;
      skip_q  <= 3'd0;
      found_q <= nalpp_pkg::CLS_UNSPEC;
    end else begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      skip_q  <= skip_d;
      found_q <= found_d;
    end
  end

endmodule

`default_nettype wire

/* design/nalpp_fifo.sv */
// ----------------------------------------------------------------------------
// nalpp_fifo: packet class queue
// Short first-in first-out queue of packet classes between scanner and scorer.
// ----------------------------------------------------------------------------
`default_nettype none

module nalpp_fifo #(
  parameter int Depth = nalpp_pkg::QueueDepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire nalpp_pkg::slice_class_e  push_data_i,
  output      logic                     full_o,
  input  wire logic                     pop_i,
  output      logic                     valid_o,
  output      nalpp_pkg::slice_class_e  data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  nalpp_pkg::slice_class_e mem_q [Depth];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]         count_q;
  logic                    do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != CntW'(0));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/nalpp_scorer.sv */
// ----------------------------------------------------------------------------
// nalpp_scorer: running state and priority score
// Updates slice and GOP terms per packet class, forms the weighted Q.16
// score over two stages and bins it into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nalpp_scorer #(
  parameter int GOP_FRAMES = nalpp_pkg::GopFramesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire nalpp_pkg::weights_t      weights_i,
  input  wire logic                     job_valid_i,
  input  wire nalpp_pkg::slice_class_e  job_class_i,
  output      logic                     job_pop_o,
  output      logic                     res_valid_o,
  input  wire logic                     res_ready_i,
  output      nalpp_pkg::result_t       res_o
);

  localparam int NW   = $clog2(GOP_FRAMES + 1);
  localparam int TgW  = nalpp_pkg::TgW;
  localparam int TW   = nalpp_pkg::TermW;
  localparam int SW   = nalpp_pkg::ScoreW;
  localparam int HW   = nalpp_pkg::HalvW;
  // one frame step of tg: 1.0 = GOP_FRAMES * StepQ + StepR
  localparam int StepQ = nalpp_pkg::OneQ16 / GOP_FRAMES;
  localparam int StepR = nalpp_pkg::OneQ16 % GOP_FRAMES;

  // running state
  nalpp_pkg::frame_class_e lfc_q, lfc_d;
  logic [HW-1:0]           halv_q, halv_d;
  logic [NW-1:0]           nfr_q, nfr_d;
  logic [TgW-1:0]          tg_q, tg_d;
  logic [NW-1:0]           tgr_q, tgr_d;

  // stage 1: terms selected
  logic                    s1_valid_q;
  nalpp_pkg::slice_class_e s1_class_q;
  nalpp_pkg::ps_sel_e      s1_ps_q, ps_d;
  logic                    s1_h_q, h_d;
  logic [HW-1:0]           s1_halv_q;
  logic [TgW-1:0]          s1_tg_q;

  // stage 2: weighted terms
  logic                    s2_valid_q;
  nalpp_pkg::slice_class_e s2_class_q;
  logic [TW-1:0]           s2_a_q, s2_b_q, s2_c_q, s2_d_q;
  logic [TW-1:0]           a_d, b_d, c_d;
  logic [TW:0]             gop_prod;

  // output register
  logic                    out_valid_q;
  nalpp_pkg::result_t      out_q;
  logic [SW-1:0]           score;
  nalpp_pkg::prio_e        bin;

  logic advance;

  assign advance   = !out_valid_q || res_ready_i;
  assign job_pop_o = advance && job_valid_i;

  // next running state for the class at the queue head
  always_comb begin
    lfc_d  = lfc_q;
    halv_d = halv_q;
    nfr_d  = nfr_q;
    tg_d   = tg_q;
    tgr_d  = tgr_q;
    ps_d   = nalpp_pkg::PS_ZERO;
    h_d    = 1'b0;
    unique case (job_class_i)
      nalpp_pkg::CLS_IDR: begin
        lfc_d  = nalpp_pkg::FRAME_IDR;
        h_d    = 1'b1;
        ps_d   = nalpp_pkg::PS_ONE;
        halv_d = '0;
        nfr_d  = '0;
        tg_d   = TgW'(nalpp_pkg::OneQ16);
        tgr_d  = '0;
      end
      nalpp_pkg::CLS_P, nalpp_pkg::CLS_B: begin
        lfc_d  = (job_class_i == nalpp_pkg::CLS_P) ? nalpp_pkg::FRAME_P
                                                   : nalpp_pkg::FRAME_B;
        ps_d   = (job_class_i == nalpp_pkg::CLS_P) ? nalpp_pkg::PS_HALF
                                                   : nalpp_pkg::PS_ZERO;
        h_d    = 1'b1;
        halv_d = '0;
        // drop tg by one frame, keep quotient and remainder; stop at zero
        if (nfr_q < NW'(GOP_FRAMES)) begin
          nfr_d = nfr_q + NW'(1);
          if (tgr_q < NW'(StepR)) begin
            tgr_d = tgr_q + NW'(GOP_FRAMES - StepR);
            tg_d  = tg_q - TgW'(StepQ) - TgW'(1);
          end else begin
            tgr_d = tgr_q - NW'(StepR);
            tg_d  = tg_q - TgW'(StepQ);
          end
        end
      end
      nalpp_pkg::CLS_UNSPEC: begin
        if (halv_q < nalpp_pkg::MaxHalvings) begin
          halv_d = halv_q + HW'(1);
        end
        unique case (lfc_q)
          nalpp_pkg::FRAME_IDR: ps_d = nalpp_pkg::PS_ONE;
          nalpp_pkg::FRAME_P:   ps_d = nalpp_pkg::PS_HALF;
          default:              ps_d = nalpp_pkg::PS_ZERO;
        endcase
      end
      default: begin
      end
    endcase
  end

  // weighted terms from stage 1
  always_comb begin
    case (s1_ps_q)
      nalpp_pkg::PS_ONE:  a_d = {weights_i.frame_type, 16'b0};
      nalpp_pkg::PS_HALF: a_d = {1'b0, weights_i.frame_type, 15'b0};
      default:            a_d = '0;
    endcase
    b_d = s1_h_q ? {weights_i.header, 16'b0} : '0;
    c_d = {weights_i.slice, 16'b0} >> s1_halv_q;
  end
  assign gop_prod = (TW + 1)'(weights_i.gop) * (TW + 1)'(s1_tg_q);

  // sum and bin
  always_comb begin
    score = SW'(s2_a_q) + SW'(s2_b_q) + SW'(s2_c_q) + SW'(s2_d_q);
    if (score > nalpp_pkg::ThrHigh) begin
      bin = nalpp_pkg::PRIO_HIGH;
    end else if (score > nalpp_pkg::ThrMedHigh) begin
      bin = nalpp_pkg::PRIO_MED_HIGH;
    end else if (score > nalpp_pkg::ThrMedLow) begin
      bin = nalpp_pkg::PRIO_MED_LOW;
    end else begin
      bin = nalpp_pkg::PRIO_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfc_q       <= nalpp_pkg::FRAME_IDR;
      halv_q      <= '0;
      nfr_q       <= '0;
      tg_q        <= TgW'(nalpp_pkg::OneQ16);
      tgr_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        lfc_q  <= lfc_d;
        halv_q <= halv_d;
        nfr_q  <= nfr_d;
        tg_q   <= tg_d;
        tgr_q  <= tgr_d;
      end
      if (advance) begin
        s1_valid_q  <= job_pop_o;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_class_q <= job_class_i;
      s1_ps_q    <= ps_d;
      s1_h_q     <= h_d;
      s1_halv_q  <= halv_d;
      s1_tg_q    <= tg_d;
      s2_class_q <= s1_class_q;
      s2_a_q     <= a_d;
      s2_b_q     <= b_d;
      s2_c_q     <= c_d;
      s2_d_q     <= gop_prod[TW-1:0];
      out_q.priority_res <= bin;
      out_q.slice_class  <= s2_class_q;
      out_q.score_whole  <= score[SW-1:SW-nalpp_pkg::WholeW];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

/* design/nal_packet_prioritizer.sv */
// ----------------------------------------------------------------------------
// nal_packet_prioritizer: NAL start code scanner and packet priority scorer
// Finds H.264 Annex B start codes in a byte stream and emits one priority
// beat per packet from a weighted Q.16 linear score.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle; one result beat per cycle sustained.
// Path: the last byte's class enters the queue on the edge that accepts it,
//   then is registered through term select, weighting and the output bin.
// Bytes stall only when the 4-entry class queue fills under m_axis_tready low.
// Reset: rst_ni is asynchronous and active low; it clears the window, queue,
//   pipeline valids, running GOP/slice state and weights at once.
// ----------------------------------------------------------------------------
`default_nettype none

module nal_packet_prioritizer #(
  parameter int GOP_FRAMES  = nalpp_pkg::GopFramesDefault,
  parameter int QUEUE_DEPTH = nalpp_pkg::QueueDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [nalpp_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [nalpp_pkg::WeightW-1:0]   cfg_data_i,
  // byte stream in
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  wire logic                            s_axis_tlast,  // last_byte
  // priority stream out
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] priority_res, [4:2] slice_class, [16:5] score_whole, [23:17] zero
  output      logic [23:0]                     m_axis_tdata
);

  nalpp_pkg::weights_t     weights_q;
  logic                    push;
  nalpp_pkg::slice_class_e push_class;
  logic                    queue_full;
  logic                    job_valid;
  logic                    job_pop;
  nalpp_pkg::slice_class_e job_class;
  nalpp_pkg::result_t      result;

  // Weights: always ready; writes beyond the register list fall through.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nalpp_pkg::CfgWeightFrameType: weights_q.frame_type <= cfg_data_i;
        nalpp_pkg::CfgWeightHeader:    weights_q.header     <= cfg_data_i;
        nalpp_pkg::CfgWeightSlice:     weights_q.slice      <= cfg_data_i;
        nalpp_pkg::CfgWeightGop:       weights_q.gop        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: scan every byte, push one class per packet at its last beat.
  nalpp_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_data_i  (s_axis_tdata),
    .byte_last_i  (s_axis_tlast),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_class_o (push_class)
  );

  // Decouple the scanner from output backpressure.
  nalpp_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_class),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .data_o      (job_class)
  );

  // Back: advance running state in packet order and score.
  nalpp_scorer #(
    .GOP_FRAMES (GOP_FRAMES)
  ) u_scorer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weights_i   (weights_q),
    .job_valid_i (job_valid),
    .job_class_i (job_class),
    .job_pop_o   (job_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (result)
  );

  assign m_axis_tdata = {7'b0, result};

endmodule

`default_nettype wire

/* design/nalpp_checker.sv */
// ----------------------------------------------------------------------------
// nalpp_checker: port-level checks of the NAL packet prioritizer
// Watches result beats for stalls, bin/score agreement, class range and padding.
// ----------------------------------------------------------------------------
`default_nettype none

module nalpp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [23:0]                     m_axis_tdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:2] <= 3'd4))
    else $error("slice class out of range");

  // a high bin needs a whole score of at least 1002; above 1002 it must be high
  a_bin_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[1:0] == 2'd3) == (m_axis_tdata[16:5] > 12'd1002) ||
                       (m_axis_tdata[16:5] == 12'd1002)))
    else $error("high bin disagrees with score");

  a_bin_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] == 2'd0)) |-> (m_axis_tdata[16:5] <= 12'd200))
    else $error("low bin with score above 200");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0))
    else $error("result padding not zero");

endmodule

bind nal_packet_prioritizer nalpp_checker u_nalpp_checker (.*);

`default_nettype wire

/* tb/tb_nal_packet_prioritizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nal_packet_prioritizer: self-checking bench for the NAL packet prioritizer
// Streams packets of bytes built around Annex B start codes (IDR, P, B,
// type-zero, other types, short and noise packets) through the byte input,
// predicts each priority beat from a behavioral scorer kept inside the bench,
// and compares every output beat field by field under random back-pressure.
// ----------------------------------------------------------------------------

module tb_nal_packet_prioritizer;
  import nalpp_pkg::*;

  localparam int GopLen      = GopFramesDefault;
  localparam int DrainCycles = 12;         // well past the beat latency
  localparam int TimeoutNs   = 2_000_000;  // far beyond a slow run
  localparam int ReportLimit = 100;
  localparam int TrafficBytes = 510;       // per random test
  localparam int Segments    = 4;          // weight settings per random test
  // no register lives here; writes must be dropped
  localparam logic [CfgIndexW-1:0] CfgUnusedIdx = '1;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [WeightW-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] data_byte
  logic                 s_axis_tlast;   // last_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [1:0] priority_res, [4:2] slice_class, [16:5] score_whole, [23:17] zero
  logic [23:0]          m_axis_tdata;

  nal_packet_prioritizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Scorer state: mirrors the block's weights, scan window and running terms
  // --------------------------------------------------------------------------
  logic [WeightW-1:0] w_frame  = '0;
  logic [WeightW-1:0] w_header = '0;
  logic [WeightW-1:0] w_slice  = '0;
  logic [WeightW-1:0] w_gop    = '0;

  logic [7:0]   win [4];
  int           bytes_held       = 0;
  int           tests_to_skip    = 0;
  slice_class_e hdr_class        = CLS_UNSPEC;
  frame_class_e last_frame       = FRAME_IDR;
  int           halvings         = 0;
  int           frames_since_idr = 0;

  result_t prio_due [$];    // priority beats predicted and not yet seen
  logic [7:0] pkt_bytes [$]; // packet under construction

  // Bookkeeping
  int mismatch_count = 0;
  int byte_count     = 0;
  int packet_count   = 0;
  int weight_sets    = 0;
  int class_hits [5];
  int bin_hits   [4];

  // Traffic shaping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int set_index     = 1;
  int run_left      = 0;
  bit run_unspec    = 1'b0;

  result_t got_beat;
  result_t want_beat;

  // --------------------------------------------------------------------------
  // Clock and output-side back-pressure
  // --------------------------------------------------------------------------
  always #2 clk_i = ~clk_i;

  // Drop tready at random on the falling edge; the rate changes per test.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Scorer: advance the window on every accepted byte; on the last byte of a
  // packet update the running terms and queue the expected priority beat.
  // --------------------------------------------------------------------------
  function automatic void score_packet_byte(input logic [7:0] b, input bit last);
    logic [7:0]        hdr;
    longint unsigned   ps;
    longint unsigned   hv;
    longint unsigned   ts;
    longint unsigned   tg;
    longint unsigned   score;
    result_t           res;
    ps = 0;
    hv = 0;
    byte_count++;

    // Test the window that started four bytes back, unless still skipping
    // the windows that overlap a start code just found.
    if (bytes_held >= 4) begin
      if (tests_to_skip > 0) begin
        tests_to_skip--;
      end else if (win[0] == 8'h00 && win[1] == 8'h00 &&
                   (win[2] == StartCodeOne ||
                    (win[2] == 8'h00 && win[3] == StartCodeOne))) begin
        // three-byte code: header already in the window; four-byte: it is b
        hdr = (win[2] == StartCodeOne) ? win[3] : b;
        if (hdr[4:0] == NalTypeUnspec) begin
          hdr_class = CLS_UNSPEC;
        end else if (hdr[4:0] == NalTypeIdr) begin
          hdr_class = CLS_IDR;
        end else if (hdr[4:0] == NalTypeSlice) begin
          hdr_class = ((hdr & HdrRefIdcMask) == 8'h00) ? CLS_B : CLS_P;
        end else begin
          hdr_class = CLS_OTHER;
        end
        tests_to_skip = 4;
      end
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2] = win[3];
    win[3] = b;
    if (bytes_held < 4) bytes_held++;

    if (!last) return;

    case (hdr_class)
      CLS_IDR: begin
        last_frame       = FRAME_IDR;
        hv               = OneQ16;
        ps               = OneQ16;
        halvings         = 0;
        frames_since_idr = 0;
      end
      CLS_P, CLS_B: begin
        last_frame = (hdr_class == CLS_P) ? FRAME_P : FRAME_B;
        hv         = OneQ16;
        ps         = (hdr_class == CLS_P) ? OneQ16 / 2 : 0;
        halvings   = 0;
        if (frames_since_idr < GopLen) frames_since_idr++;
      end
      CLS_UNSPEC: begin
        // continuation slice: halve ts, frame term follows the last frame
        if (halvings < MaxHalvings) halvings++;
        case (last_frame)
          FRAME_IDR: ps = OneQ16;
          FRAME_P:   ps = OneQ16 / 2;
          default:   ps = 0;
        endcase
      end
      default: ;  // other NAL types leave the running state alone
    endcase

    ts    = longint'(OneQ16) >> halvings;
    tg    = (longint'(GopLen - frames_since_idr) * OneQ16) / GopLen;
    score = w_frame * ps + w_header * hv + w_slice * ts + w_gop * tg;

    if (score > ThrHigh) begin
      res.priority_res = PRIO_HIGH;
    end else if (score > ThrMedHigh) begin
      res.priority_res = PRIO_MED_HIGH;
    end else if (score > ThrMedLow) begin
      res.priority_res = PRIO_MED_LOW;
    end else begin
      res.priority_res = PRIO_LOW;
    end
    res.slice_class = hdr_class;
    res.score_whole = WholeW'(score >> 16);
    prio_due.push_back(res);

    packet_count++;
    class_hits[hdr_class]++;
    bin_hits[res.priority_res]++;

    // clear the per-packet scan state
    foreach (win[i]) win[i] = 8'h00;
    bytes_held    = 0;
    tests_to_skip = 0;
    hdr_class     = CLS_UNSPEC;
  endfunction

  // --------------------------------------------------------------------------
  // Output checker: every beat against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end else if (mismatch_count == ReportLimit + 1) begin
      $display("%0t ns: further mismatches are counted without detail", $time);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat = result_t'(m_axis_tdata[16:0]);
      if (prio_due.size() == 0) begin
        note_mismatch("unexpected beat, tdata", -1, int'(m_axis_tdata));
      end else begin
        want_beat = prio_due.pop_front();
        if (got_beat.priority_res !== want_beat.priority_res)
          note_mismatch("priority_res", want_beat.priority_res, got_beat.priority_res);
        if (got_beat.slice_class !== want_beat.slice_class)
          note_mismatch("slice_class", want_beat.slice_class, got_beat.slice_class);
        if (got_beat.score_whole !== want_beat.score_whole)
          note_mismatch("score_whole", want_beat.score_whole, got_beat.score_whole);
        if (m_axis_tdata[23:17] !== '0)
          note_mismatch("tdata padding", 0, int'(m_axis_tdata[23:17]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte and packet drivers
  // --------------------------------------------------------------------------
  // Present one byte on the falling edge after optional idle cycles, hold it
  // until accepted, then score it. tvalid stays high on return so the next
  // byte can follow back to back.
  task automatic send_byte(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    score_packet_byte(b, last);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // Hold the byte input idle until every predicted beat has come out, then
  // give the pipeline time to empty completely.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (prio_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [CfgIndexW-1:0] idx,
                              input logic [WeightW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgWeightFrameType: w_frame  = val;
      CfgWeightHeader:    w_header = val;
      CfgWeightSlice:     w_slice  = val;
      CfgWeightGop:       w_gop    = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Weight settings: extremes, exact bin boundaries, then random ones.
  task automatic load_weights(input int set);
    logic [WeightW-1:0] wf;
    logic [WeightW-1:0] wh;
    logic [WeightW-1:0] ws;
    logic [WeightW-1:0] wg;
    wf = '0;
    wh = '0;
    ws = '0;
    wg = '0;
    case (set)
      0: begin wf = '1; wh = '1; ws = '1; wg = '1; end
      1: ;                                 // all zero
      2: wh = 10'd1002;                    // header alone sits on the top bound
      3: wh = 10'd1003;                    // one above it
      4: ws = 10'd700;                     // fresh ts sits on the middle bound
      5: wg = 10'd201;                     // fresh tg just over the low bound
      6: begin wf = 10'd400; wh = 10'd600; ws = 10'd300; wg = 10'd500; end
      7: begin wf = '1; ws = 10'd512; end
      default: begin
        wf = 10'($urandom_range(1023));
        wh = 10'($urandom_range(1023));
        ws = 10'($urandom_range(1023));
        wg = 10'($urandom_range(1023));
      end
    endcase
    write_weight(CfgWeightFrameType, wf);
    write_weight(CfgWeightHeader, wh);
    write_weight(CfgWeightSlice, ws);
    write_weight(CfgWeightGop, wg);
    // a write to a missing register must change nothing
    if (set % 3 == 0) write_weight(CfgUnusedIdx, 10'($urandom));
    weight_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Packet construction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hdr_byte(input logic [1:0] ref_idc,
                                          input logic [4:0] nal_type);
    return {1'b0, ref_idc, nal_type};
  endfunction

  // Bias toward 00 and 01 so partial and broken start codes turn up often.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return StartCodeOne;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] make_header(input slice_class_e want);
    logic [7:0] hdr;
    logic [4:0] typ;
    case (want)
      CLS_IDR:    hdr = hdr_byte(2'($urandom_range(3)), NalTypeIdr);
      CLS_P:      hdr = hdr_byte(2'($urandom_range(1, 3)), NalTypeSlice);
      CLS_B:      hdr = hdr_byte(2'd0, NalTypeSlice);
      CLS_UNSPEC: hdr = hdr_byte(2'($urandom_range(3)), NalTypeUnspec);
      default: begin
        do typ = 5'($urandom_range(2, 31)); while (typ == NalTypeIdr);
        hdr = hdr_byte(2'($urandom_range(3)), typ);
      end
    endcase
    hdr[7] = 1'($urandom);   // forbidden bit is not checked by the block
    return hdr;
  endfunction

  function automatic slice_class_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 10) return CLS_IDR;
    if (r < 40) return CLS_P;
    if (r < 60) return CLS_B;
    if (r < 85) return CLS_UNSPEC;
    return CLS_OTHER;
  endfunction

  // Build one packet. A clean packet has no noise prefix and opens with a start
  // code and the wanted header; unspecified clean packets are short.
  function automatic void build_packet(input slice_class_e want, input bit clean);
    int pre;
    int body;
    pkt_bytes.delete();
    pre = clean ? 0 : $urandom_range(0, 3);
    repeat (pre) pkt_bytes.push_back(rand_byte());
    if (want == CLS_UNSPEC && (clean || $urandom_range(1))) begin
      body = clean ? $urandom_range(1, 3) : $urandom_range(1, 9);
      repeat (body) pkt_bytes.push_back(rand_byte());
    end else begin
      if ($urandom_range(1)) pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(StartCodeOne);
      pkt_bytes.push_back(make_header(want));
      body = ($urandom_range(9) == 0) ? $urandom_range(20, 48)
                                      : $urandom_range(clean ? 1 : 0, 8);
      repeat (body) pkt_bytes.push_back(rand_byte());
      // now and then a second header later in the packet overrides the first
      if (!clean && $urandom_range(7) == 0) begin
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(StartCodeOne);
        pkt_bytes.push_back(make_header(pick_kind()));
        pkt_bytes.push_back(rand_byte());
      end
    end
  endfunction

  // Random traffic in segments, each under a fresh weight setting loaded
  // while the block is idle. Long runs of continuation packets or of P/B
  // frames push ts and tg into saturation.
  task automatic run_traffic(input int nbytes);
    int sent;
    for (int seg = 0; seg < Segments; seg++) begin
      settle();
      load_weights(set_index);
      set_index++;
      sent = 0;
      while (sent < nbytes / Segments) begin
        if (run_left == 0 && $urandom_range(99) < 3) begin
          run_left   = $urandom_range(18, 24);
          run_unspec = 1'($urandom);
        end
        if (run_left > 0) begin
          run_left--;
          build_packet(run_unspec ? CLS_UNSPEC : ($urandom_range(1) ? CLS_P : CLS_B),
                       1'b1);
        end else begin
          build_packet(pick_kind(), 1'b0);
        end
        send_packet();
        sent += pkt_bytes.size();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Weights are zero out of reset: every score must come out as zero.
  task automatic test_reset_weights();
    pkt_bytes = '{8'hFF};
    send_packet();
    pkt_bytes = '{8'h00};
    send_packet();
  endtask

  // One packet per header kind at full weights, plus a short packet.
  task automatic test_header_kinds();
    settle();
    load_weights(0);
    // four-byte code, header is the last byte
    pkt_bytes = '{8'h00, 8'h00, 8'h00, StartCodeOne, hdr_byte(2'd3, NalTypeIdr)};
    send_packet();
    // three-byte codes: P, B, type zero, other
    pkt_bytes = '{8'h00, 8'h00, StartCodeOne, hdr_byte(2'd2, NalTypeSlice), 8'h7F};
    send_packet();
    pkt_bytes = '{8'h00, 8'h00, StartCodeOne, hdr_byte(2'd0, NalTypeSlice), 8'hFF};
    send_packet();
    pkt_bytes = '{8'h00, 8'h00, StartCodeOne, hdr_byte(2'd0, NalTypeUnspec), 8'h00};
    send_packet();
    pkt_bytes = '{8'h00, 8'h00, StartCodeOne, 8'h86, 8'h80};  // SEI, bit 7 set
    send_packet();
    // too short for any window test
    pkt_bytes = '{StartCodeOne};
    send_packet();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 21;
    recv_idle_pct = 87;
    run_traffic(TrafficBytes);
  endtask

  task automatic test_receiver_gaps();
    send_idle_pct = 87;
    recv_idle_pct = 21;
    run_traffic(TrafficBytes);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(TrafficBytes);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    foreach (win[i]) win[i] = 8'h00;
    foreach (class_hits[i]) class_hits[i] = 0;
    foreach (bin_hits[i]) bin_hits[i] = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_weights();
    test_header_kinds();
    test_sender_gaps();
    test_receiver_gaps();
    test_full_rate();
    settle();

    $display("Covered %0d bytes in %0d packets under %0d weight settings",
             byte_count, packet_count, weight_sets);
    $display("Classes idr/p/b/unspec/other %0d/%0d/%0d/%0d/%0d, bins %0d/%0d/%0d/%0d",
             class_hits[CLS_IDR], class_hits[CLS_P], class_hits[CLS_B],
             class_hits[CLS_UNSPEC], class_hits[CLS_OTHER],
             bin_hits[PRIO_LOW], bin_hits[PRIO_MED_LOW],
             bin_hits[PRIO_MED_HIGH], bin_hits[PRIO_HIGH]);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TimeoutNs);
    $display("%0t ns: timeout with %0d beats outstanding", $time, prio_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
